@@ rtl/tcce_pkg.sv @@
// Shared types, codes and defaults of the text console cursor engine.
package tcce_pkg;

  // Default console geometry
  localparam int TCCE_MAX_COLS  = 64;
  localparam int TCCE_MAX_ROWS  = 32;
  localparam int TCCE_TAB_WIDTH = 8;

  // Character cell size in pixels
  localparam int CELL_W = 6;
  localparam int CELL_H = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS  = 3'd0,
    CFG_ROWS     = 3'd1,
    CFG_BG_COLOR = 3'd2,
    CFG_FG_COLOR = 3'd3,
    CFG_ORIGIN_X = 3'd4,
    CFG_ORIGIN_Y = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam logic [6:0] RST_COLUMNS  = 7'd53;
  localparam logic [5:0] RST_ROWS     = 6'd30;
  localparam logic [3:0] RST_BG_COLOR = 4'd15;
  localparam logic [3:0] RST_FG_COLOR = 4'd0;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // Control characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // One stored cell: character and packed colour (background high nibble)
  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] color;
  } cell_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_PUT,
    ST_RDATA,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_CLR
  } state_t;

endpackage

@@ rtl/tcce_cell_ram.sv @@
// Cell store: one write port, one read port with registered read data.
module tcce_cell_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  tcce_pkg::cell_t     wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output tcce_pkg::cell_t     rdata
);
  import tcce_pkg::*;

  cell_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/text_console_cursor_engine_unit.sv @@
// Top level of the text console cursor engine: sequencer, cursor and registers.
//
//  channel   signals                                  handshake
//  request   start, kind, char_code, cell_column,     taken when start & !busy
//            cell_row
//  result    done, echo_char, cursor_column,          one cycle, done high,
//            cursor_row, scrolled, glyph*,            cannot be held off
//  config    cfg_write, cfg_index, cfg_data           taken when cfg_write
//
// Control codes that do not scroll, no-ops and reads outside the active area
// give their result in the cycle after the request; a stored character first
// passes ST_PUT (cell write), an in-range read ST_RDATA (store read latency).
// A scroll walks the store through its single read and write port: ST_SCR_RD
// and ST_SCR_WR alternate over the kept rows, ST_SCR_CLR blanks the last row.
// Clear, and reset, run a clearing pass over all MAX_COLS*MAX_ROWS cells with
// busy high; the clear result comes at its end. The result side cannot stall.
module text_console_cursor_engine_unit #(
  parameter int MAX_COLS  = tcce_pkg::TCCE_MAX_COLS,
  parameter int MAX_ROWS  = tcce_pkg::TCCE_MAX_ROWS,
  parameter int TAB_WIDTH = tcce_pkg::TCCE_TAB_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      char_code,
  input  logic [5:0]                      cell_column,
  input  logic [4:0]                      cell_row,
  input  logic                            cfg_write,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            done,
  output logic [7:0]                      echo_char,
  output logic [6:0]                      cursor_column,
  output logic [4:0]                      cursor_row,
  output logic                            scrolled,
  output logic [7:0]                      glyph,
  output logic [3:0]                      glyph_background,
  output logic [3:0]                      glyph_foreground,
  output logic [10:0]                     glyph_pixel_x,
  output logic [10:0]                     glyph_pixel_y
);
  import tcce_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int LINE_W = $clog2(MAX_ROWS);
  localparam int PH_W   = $clog2(TAB_WIDTH);
  localparam int TAB_SUM_W = COL_W + 2;
  localparam logic [PH_W-1:0] SAT_PHASE = PH_W'(MAX_COLS % TAB_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Configuration registers
  logic [6:0] columns;
  logic [5:0] rows;
  logic [3:0] bg_color;
  logic [3:0] fg_color;
  logic [9:0] pixel_origin_x;
  logic [9:0] pixel_origin_y;

  // Sequencer and cursor
  state_t              state, state_next;
  logic [ADDR_W-1:0]   cnt;
  logic [7:0]          fill_color;
  logic                clr_reply;
  logic                pend_put;
  logic [7:0]          put_char;
  logic [COL_W-1:0]    cur_col;
  logic [LINE_W-1:0]   cur_line;
  logic [PH_W-1:0]     phase;

  // Store ports
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  cell_t               ram_wdata, ram_rdata;

  // Derived values
  logic [COL_W-1:0]    nc;
  logic [ROW_W-1:0]    nr;
  logic [7:0]          packed_color;
  logic [ADDR_W-1:0]   keep;
  logic [ADDR_W-1:0]   clr_last;
  logic [ADDR_W-1:0]   rd_idx;
  logic [ADDR_W-1:0]   put_idx;
  logic [ROW_W-1:0]    nl_line;
  logic                nl_scroll;
  logic                wrap;
  logic [ROW_W-1:0]    w_line;
  logic                w_scroll;
  logic                rd_in_range;
  logic [TAB_SUM_W-1:0] tab_sum;
  logic                accept;
  kind_t               req_kind;
  state_t              scr_first;

  assign accept   = start && (state == ST_IDLE) && !rst;
  assign busy     = rst || (state != ST_IDLE);
  assign req_kind = kind_t'(kind);

  // Clamp the active geometry
  always_comb begin
    if (columns == 7'd0) begin
      nc = COL_W'(1);
    end else if (int'(columns) > MAX_COLS) begin
      nc = COL_W'(MAX_COLS);
    end else begin
      nc = COL_W'(columns);
    end
    if (rows == 6'd0) begin
      nr = ROW_W'(1);
    end else if (int'(rows) > MAX_ROWS) begin
      nr = ROW_W'(MAX_ROWS);
    end else begin
      nr = ROW_W'(rows);
    end
  end

  assign packed_color = {bg_color, fg_color};

  // Cell addresses and scroll bounds
  assign keep     = ADDR_W'(ADDR_W'(nr - ROW_W'(1)) * ADDR_W'(nc));
  assign clr_last = ADDR_W'(keep + ADDR_W'(nc) - ADDR_W'(1));
  assign rd_idx   = ADDR_W'(ADDR_W'(cell_row) * ADDR_W'(nc) + ADDR_W'(cell_column));
  assign put_idx  = ADDR_W'(ADDR_W'(cur_line) * ADDR_W'(nc) + ADDR_W'(cur_col));

  // Cursor decisions for a put request
  assign nl_line     = ROW_W'(cur_line) + ROW_W'(1);
  assign nl_scroll   = nl_line >= nr;
  assign wrap        = cur_col >= nc;
  assign w_line      = wrap ? nl_line : ROW_W'(cur_line);
  assign w_scroll    = w_line >= nr;
  assign rd_in_range = (int'(cell_column) < int'(nc)) && (int'(cell_row) < int'(nr));
  assign tab_sum     = TAB_SUM_W'(cur_col) + TAB_SUM_W'(TAB_WIDTH) - TAB_SUM_W'(phase);
  assign scr_first   = (keep == '0) ? ST_SCR_CLR : ST_SCR_RD;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (cnt == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req_kind)
            KIND_PUT: begin
              unique case (char_code)
                CH_LF:  state_next = nl_scroll ? scr_first : ST_IDLE;
                CH_CR, CH_BS, CH_TAB: state_next = ST_IDLE;
                default: state_next = w_scroll ? scr_first : ST_PUT;
              endcase
            end
            KIND_CLEAR: state_next = ST_FILL;
            KIND_READ:  state_next = rd_in_range ? ST_RDATA : ST_IDLE;
            KIND_NOP:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_PUT:    state_next = ST_IDLE;
      ST_RDATA:  state_next = ST_IDLE;
      ST_SCR_RD: state_next = ST_SCR_WR;
      ST_SCR_WR: begin
        state_next = (cnt == ADDR_W'(keep - ADDR_W'(1))) ? ST_SCR_CLR : ST_SCR_RD;
      end
      ST_SCR_CLR: begin
        if (cnt == clr_last) state_next = pend_put ? ST_PUT : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Store access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '{glyph: CH_NUL, color: packed_color};
    ram_re    = 1'b0;
    ram_raddr = rd_idx;
    unique case (state)
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = '{glyph: CH_NUL, color: fill_color};
      end
      ST_IDLE: begin
        ram_re = accept && (req_kind == KIND_READ) && rd_in_range;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = put_idx;
        ram_wdata = '{glyph: put_char, color: packed_color};
      end
      ST_RDATA: begin
      end
      ST_SCR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(cnt + ADDR_W'(nc));
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_SCR_CLR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      columns        <= RST_COLUMNS;
      rows           <= RST_ROWS;
      bg_color       <= RST_BG_COLOR;
      fg_color       <= RST_FG_COLOR;
      pixel_origin_x <= '0;
      pixel_origin_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLUMNS:  columns        <= cfg_data[6:0];
        CFG_ROWS:     rows           <= cfg_data[5:0];
        CFG_BG_COLOR: bg_color       <= cfg_data[3:0];
        CFG_FG_COLOR: fg_color       <= cfg_data[3:0];
        CFG_ORIGIN_X: pixel_origin_x <= cfg_data;
        CFG_ORIGIN_Y: pixel_origin_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Cursor, sweep control and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      fill_color <= {RST_BG_COLOR, RST_FG_COLOR};
      clr_reply  <= 1'b0;
      pend_put   <= 1'b0;
      cur_col    <= '0;
      cur_line   <= '0;
      phase      <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_FILL: begin
          cnt <= ADDR_W'(cnt + ADDR_W'(1));
          if (cnt == LAST_ADDR) done <= clr_reply;
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (req_kind)
              KIND_PUT: begin
                unique case (char_code)
                  CH_LF: begin
                    cur_col <= '0;
                    phase   <= '0;
                    if (nl_scroll) begin
                      cur_line <= LINE_W'(nr - ROW_W'(1));
                      cnt      <= '0;
                      pend_put <= 1'b0;
                    end else begin
                      cur_line <= LINE_W'(nl_line);
                      done     <= 1'b1;
                    end
                  end
                  CH_CR: begin
                    cur_col <= '0;
                    phase   <= '0;
                    done    <= 1'b1;
                  end
                  CH_BS: begin
                    if (cur_col != '0) begin
                      cur_col <= cur_col - COL_W'(1);
                      phase   <= (phase == '0) ? PH_W'(TAB_WIDTH - 1) : phase - PH_W'(1);
                    end
                    done <= 1'b1;
                  end
                  CH_TAB: begin
                    // Advance to the next tab stop, saturate at MAX_COLS, one past the last column
                    if (int'(tab_sum) > MAX_COLS) begin
                      cur_col <= COL_W'(MAX_COLS);
                      phase   <= SAT_PHASE;
                    end else begin
                      cur_col <= COL_W'(tab_sum);
                      phase   <= '0;
                    end
                    done <= 1'b1;
                  end
                  default: begin
                    put_char <= char_code;
                    if (w_scroll) begin
                      cur_line <= LINE_W'(nr - ROW_W'(1));
                      cur_col  <= '0;
                      phase    <= '0;
                      cnt      <= '0;
                      pend_put <= 1'b1;
                    end else if (wrap) begin
                      cur_line <= LINE_W'(w_line);
                      cur_col  <= '0;
                      phase    <= '0;
                    end
                  end
                endcase
              end
              KIND_CLEAR: begin
                cnt        <= '0;
                fill_color <= packed_color;
                clr_reply  <= 1'b1;
                cur_col    <= '0;
                cur_line   <= '0;
                phase      <= '0;
              end
              KIND_READ: begin
                if (!rd_in_range) done <= 1'b1;
              end
              KIND_NOP: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_PUT: begin
          cur_col  <= cur_col + COL_W'(1);
          phase    <= (phase == PH_W'(TAB_WIDTH - 1)) ? '0 : phase + PH_W'(1);
          pend_put <= 1'b0;
          done     <= 1'b1;
        end
        ST_RDATA: begin
          done <= 1'b1;
        end
        ST_SCR_RD: begin
        end
        ST_SCR_WR: begin
          cnt <= ADDR_W'(cnt + ADDR_W'(1));
        end
        ST_SCR_CLR: begin
          cnt <= ADDR_W'(cnt + ADDR_W'(1));
          if (cnt == clr_last && !pend_put) done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_char        <= 8'd0;
      scrolled         <= 1'b0;
      glyph            <= 8'd0;
      glyph_background <= 4'd0;
      glyph_foreground <= 4'd0;
      glyph_pixel_x    <= 11'd0;
      glyph_pixel_y    <= 11'd0;
      unique case (req_kind)
        KIND_PUT: begin
          echo_char <= (char_code == CH_TAB) ? CH_SPACE : char_code;
          if (char_code == CH_LF) begin
            scrolled <= nl_scroll;
          end else if (char_code != CH_CR && char_code != CH_BS && char_code != CH_TAB) begin
            scrolled <= w_scroll;
          end
        end
        KIND_READ: begin
          glyph_pixel_x <= 11'(pixel_origin_x) + 11'(cell_column) * 11'(CELL_W);
          glyph_pixel_y <= 11'(pixel_origin_y) + 11'(cell_row) * 11'(CELL_H);
          // Outside the active area show a blank cell in the configured colours
          glyph            <= CH_SPACE;
          glyph_background <= bg_color;
          glyph_foreground <= fg_color;
        end
        KIND_CLEAR, KIND_NOP: begin
        end
      endcase
    end else if (state == ST_RDATA) begin
      glyph            <= (ram_rdata.glyph == CH_NUL) ? CH_SPACE : ram_rdata.glyph;
      glyph_background <= ram_rdata.color[7:4];
      glyph_foreground <= ram_rdata.color[3:0];
    end
  end

  assign cursor_column = 7'(cur_col);
  assign cursor_row    = 5'(cur_line);

  tcce_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
